// ===== rtl/eb_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// eb_alu_pkg
// Operation codes, flag bit positions and field types for the 8-bit cpu alu
// ----------------------------------------------------------------------------
package eb_alu_pkg;

    typedef logic [3:0]  action_t;
    typedef logic [15:0] word_t;
    typedef logic [7:0]  flags_t;

    localparam action_t ACT_ADD8  = 4'd0;
    localparam action_t ACT_ADC8  = 4'd1;
    localparam action_t ACT_SUB8  = 4'd2;
    localparam action_t ACT_SBC8  = 4'd3;
    localparam action_t ACT_CP8   = 4'd4;
    localparam action_t ACT_INC8  = 4'd5;
    localparam action_t ACT_DEC8  = 4'd6;
    localparam action_t ACT_ADD16 = 4'd7;
    localparam action_t ACT_ADC16 = 4'd8;
    localparam action_t ACT_SBC16 = 4'd9;
    localparam action_t ACT_INC16 = 4'd10;
    localparam action_t ACT_DEC16 = 4'd11;

    // flag byte layout: S Z Y H X PV N C
    localparam int FLAG_C_BIT  = 0;
    localparam int FLAG_N_BIT  = 1;
    localparam int FLAG_PV_BIT = 2;
    localparam int FLAG_X_BIT  = 3;
    localparam int FLAG_H_BIT  = 4;
    localparam int FLAG_Y_BIT  = 5;
    localparam int FLAG_Z_BIT  = 6;
    localparam int FLAG_S_BIT  = 7;

endpackage

// ===== rtl/eight_bit_cpu_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// Z80-style 8/16-bit arithmetic unit with flag update, valid/ready streaming
// ----------------------------------------------------------------------------
// Usage:
//   the s_ channel takes one item per cycle while s_ready is high: operation
//   code, two operands and the current flag byte. the m_ channel returns the
//   result word and the new flag byte, one result item per input item, in order.
//   path: an accepted item is captured in the input register, then goes
//   through the alu logic into the result register and shows on m_.
//   throughput: one item per cycle, set by the two-stage register pipeline;
//   both stages move together whenever m_ready is high.
//   stalls: when m_ready is low the result register holds, the input
//   register fills, and s_ready falls once both stages hold an item; no
//   item is dropped.
//   reset: aresetn low at a rising edge empties both stages; s_ready is
//   high and m_valid low right after reset.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  eb_alu_pkg::action_t s_action,
    input  eb_alu_pkg::word_t   s_first,
    input  eb_alu_pkg::word_t   s_second,
    input  eb_alu_pkg::flags_t  s_flags_in,
    output logic                m_valid,
    input  logic                m_ready,
    output eb_alu_pkg::word_t   m_result,
    output eb_alu_pkg::flags_t  m_flags_out
);
    import eb_alu_pkg::*;

    logic    in_valid_reg;
    action_t action_reg;
    word_t   first_reg;
    word_t   second_reg;
    flags_t  flags_reg;

    logic    out_valid_reg;
    word_t   result_reg;
    flags_t  flags_out_reg;

    word_t   result_next;
    flags_t  flags_out_next;
    logic    out_ready;
    logic    advance;

    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    eb_alu_core u_core (
        .action    (action_reg),
        .first     (first_reg),
        .second    (second_reg),
        .flags_in  (flags_reg),
        .result    (result_next),
        .flags_out (flags_out_next)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            first_reg  <= s_first;
            second_reg <= s_second;
            flags_reg  <= s_flags_in;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg    <= result_next;
            flags_out_reg <= flags_out_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_result    = result_reg;
    assign m_flags_out = flags_out_reg;

`ifndef SYNTHESIS
    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("item lost between stages");

    a_inc16_dec16_keep_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (action_reg == ACT_INC16 || action_reg == ACT_DEC16))
        |=> (m_flags_out == $past(flags_reg)))
        else $error("16-bit inc/dec changed flags");

    a_cp8_keeps_operand: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && action_reg == ACT_CP8) |=> (m_result == $past(first_reg)))
        else $error("compare altered the result");
`endif

endmodule

// ===== rtl/eb_alu_core.sv =====
// ----------------------------------------------------------------------------
// eb_alu_core
// Combinational 8/16-bit add and subtract with Z80 flag generation
// ----------------------------------------------------------------------------
module eb_alu_core (
    input  eb_alu_pkg::action_t action,
    input  eb_alu_pkg::word_t   first,
    input  eb_alu_pkg::word_t   second,
    input  eb_alu_pkg::flags_t  flags_in,
    output eb_alu_pkg::word_t   result,
    output eb_alu_pkg::flags_t  flags_out
);
    import eb_alu_pkg::*;

    logic       sub8;
    logic       cin8;
    logic [7:0] a8;
    logic [7:0] b8;
    logic [8:0] t8;
    logic [7:0] r8;
    logic       v8;
    flags_t     f8;

    logic        sub16;
    logic        cin16;
    logic [16:0] t16;
    logic [15:0] r16;
    logic        v16;
    flags_t      f16;

    logic carry;

    assign carry = flags_in[FLAG_C_BIT];

    // 8-bit datapath
    assign a8   = first[7:0];
    assign b8   = (action == ACT_INC8 || action == ACT_DEC8) ? 8'd1 : second[7:0];
    assign sub8 = (action == ACT_SUB8 || action == ACT_SBC8 || action == ACT_CP8 ||
                   action == ACT_DEC8);
    assign cin8 = (action == ACT_ADC8 || action == ACT_SBC8) ? carry : 1'b0;
    assign t8   = sub8 ? ({1'b0, a8} - {1'b0, b8} - {8'd0, cin8})
                       : ({1'b0, a8} + {1'b0, b8} + {8'd0, cin8});
    assign r8   = t8[7:0];
    assign v8   = sub8 ? ((a8[7] ^ b8[7]) & (a8[7] ^ r8[7]))
                       : (~(a8[7] ^ b8[7]) & (a8[7] ^ r8[7]));
    assign f8   = {r8[7], (r8 == 8'd0), r8[5], a8[4] ^ b8[4] ^ r8[4], r8[3],
                   v8, sub8, t8[8]};

    // 16-bit datapath
    assign sub16 = (action == ACT_SBC16);
    assign cin16 = (action == ACT_ADC16 || action == ACT_SBC16) ? carry : 1'b0;
    assign t16   = sub16 ? ({1'b0, first} - {1'b0, second} - {16'd0, cin16})
                         : ({1'b0, first} + {1'b0, second} + {16'd0, cin16});
    assign r16   = t16[15:0];
    assign v16   = sub16 ? ((first[15] ^ second[15]) & (first[15] ^ r16[15]))
                         : (~(first[15] ^ second[15]) & (first[15] ^ r16[15]));
    assign f16   = {r16[15], (r16 == 16'd0), r16[13], first[12] ^ second[12] ^ r16[12],
                    r16[11], v16, sub16, t16[16]};

    always_comb begin
        result    = first;
        flags_out = flags_in;
        unique case (action) inside
            ACT_ADD8, ACT_ADC8, ACT_SUB8, ACT_SBC8: begin
                result    = {8'd0, r8};
                flags_out = f8;
            end
            ACT_CP8: begin
                result    = first;
                flags_out = f8;
                flags_out[FLAG_Y_BIT] = b8[5];
                flags_out[FLAG_X_BIT] = b8[3];
            end
            ACT_INC8, ACT_DEC8: begin
                result    = {8'd0, r8};
                flags_out = f8;
                flags_out[FLAG_C_BIT] = carry;
            end
            ACT_ADD16: begin
                result    = r16;
                flags_out = {flags_in[FLAG_S_BIT], flags_in[FLAG_Z_BIT], r16[13],
                             f16[FLAG_H_BIT], r16[11], flags_in[FLAG_PV_BIT], 1'b0,
                             f16[FLAG_C_BIT]};
            end
            ACT_ADC16, ACT_SBC16: begin
                result    = r16;
                flags_out = f16;
            end
            ACT_INC16: begin
                result = first + 16'd1;
            end
            ACT_DEC16: begin
                result = first - 16'd1;
            end
            default: begin
                result    = first;
                flags_out = flags_in;
            end
        endcase
    end

endmodule
